@@ sv/ucode_stack_machine_execute_defines.svh @@
// Assertion macros used by the stack machine top level.
// Depends on nothing; included by the top level.
`ifndef UCODE_STACK_MACHINE_EXECUTE_DEFINES_SVH
`define UCODE_STACK_MACHINE_EXECUTE_DEFINES_SVH
// Checks that an implication holds at every edge outside reset.
`define USM_ASSERT(label, clk_s, rst_s, prop, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (prop)) else $error(msg);
// Checks that a signal keeps its value at the edge after a condition.
`define USM_ASSERT_HOLD(label, clk_s, rst_s, cond, sig, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (cond) |=> $stable(sig)) \
    else $error(msg);
`endif

@@ sv/usm_pkg.sv @@
// Package for the stack machine: opcodes, fault codes, states, commands.
// Depends on nothing.
package usm_pkg;
  localparam int OPERAND_STACK_DEPTH_DEF = 64;
  localparam int DATA_WORDS_DEF = 1024;
  localparam int RETURN_STACK_DEPTH_DEF = 32;
  localparam int PROGRAM_WORDS_DEF = 4096;
  localparam int PcW = 12;
  localparam int WordW = 32;

  localparam logic [5:0] OP_LOD = 6'd3, OP_LDA = 6'd4, OP_LDC = 6'd5, OP_STR = 6'd6,
    OP_LDI = 6'd7, OP_STI = 6'd8, OP_NOT = 6'd9, OP_NEG = 6'd10, OP_INC = 6'd11,
    OP_DEC = 6'd12, OP_DUP = 6'd13, OP_ADD = 6'd14, OP_SUB = 6'd15, OP_MULT = 6'd16,
    OP_DIV = 6'd17, OP_MOD = 6'd18, OP_GT = 6'd19, OP_LT = 6'd20, OP_GE = 6'd21,
    OP_LE = 6'd22, OP_EQ = 6'd23, OP_NE = 6'd24, OP_AND = 6'd25, OP_OR = 6'd26,
    OP_SWP = 6'd27, OP_UJP = 6'd28, OP_TJP = 6'd29, OP_FJP = 6'd30, OP_CALL = 6'd31,
    OP_END = 6'd36, OP_LAST = 6'd36;

  localparam logic [2:0] F_OK = 3'd0, F_ILLEGAL = 3'd1, F_DIVZERO = 3'd2,
    F_OVERFLOW = 3'd3, F_UNDERFLOW = 3'd4, F_BADADDR = 3'd5;
  localparam logic [1:0] K_NONE = 2'd0, K_NUMBER = 2'd1, K_NEWLINE = 2'd2;
  localparam logic [1:0] CFG_START = 2'd0, CFG_WRITE = 2'd1, CFG_NEWLINE = 2'd2,
    CFG_READ = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_EXEC, S_DIV, S_OUT
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic take;     // latch the input beat and issue stack reads
    logic exec;     // stack data valid: evaluate
    logic div_go;   // start the divider
    logic commit;   // write back the evaluated instruction
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic need_div;
    logic div_done;
  } stat_t;

  function automatic logic [1:0] pops_of(input logic [5:0] op);
    case (op)
      OP_STR, OP_LDI, OP_NOT, OP_NEG, OP_INC, OP_DEC, OP_DUP, OP_TJP, OP_FJP: pops_of = 2'd1;
      OP_STI, OP_ADD, OP_SUB, OP_MULT, OP_DIV, OP_MOD, OP_GT, OP_LT, OP_GE, OP_LE,
      OP_EQ, OP_NE, OP_AND, OP_OR, OP_SWP: pops_of = 2'd2;
      default: pops_of = 2'd0;
    endcase
  endfunction

  function automatic logic [1:0] pushes_of(input logic [5:0] op);
    case (op)
      OP_DUP, OP_SWP: pushes_of = 2'd2;
      OP_LOD, OP_LDA, OP_LDC, OP_LDI, OP_NOT, OP_NEG, OP_INC, OP_DEC, OP_ADD, OP_SUB,
      OP_MULT, OP_DIV, OP_MOD, OP_GT, OP_LT, OP_GE, OP_LE, OP_EQ, OP_NE, OP_AND,
      OP_OR: pushes_of = 2'd1;
      default: pushes_of = 2'd0;
    endcase
  endfunction
endpackage

@@ sv/usm_ram.sv @@
// Generic single-port-write RAM with one registered read port.
// Depends on nothing.
module usm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ sv/usm_div.sv @@
// Radix-2 signed divider, one quotient bit per cycle, C truncation.
// Depends on usm_pkg.
module usm_div import usm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             go,
  input  logic [WordW-1:0] dividend,
  input  logic [WordW-1:0] divisor,
  output logic             done,
  output logic [WordW-1:0] quot,
  output logic [WordW-1:0] rem
);
  logic [WordW-1:0] q, d, r;
  logic [WordW:0] trial;
  logic [5:0] cnt;
  logic busy, qneg, rneg;
  logic [WordW-1:0] r_sh;

  assign r_sh = {r[WordW-2:0], q[WordW-1]};
  assign trial = {1'b0, r_sh} - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        cnt <= 6'd0;
        q <= dividend[WordW-1] ? 32'd0 - dividend : dividend;
        d <= divisor[WordW-1] ? 32'd0 - divisor : divisor;
        r <= '0;
        qneg <= dividend[WordW-1] ^ divisor[WordW-1];
        rneg <= dividend[WordW-1];
      end else if (busy) begin
        if (cnt == 6'(WordW)) begin
          busy <= 1'b0;
          done <= 1'b1;
          quot <= qneg ? 32'd0 - q : q;
          rem <= rneg ? 32'd0 - r : r;
        end else begin
          cnt <= cnt + 6'd1;
          if (!trial[WordW]) begin
            r <= trial[WordW-1:0];
            q <= {q[WordW-2:0], 1'b1};
          end else begin
            r <= r_sh;
            q <= {q[WordW-2:0], 1'b0};
          end
        end
      end
    end
  end
endmodule

@@ sv/usm_ctrl.sv @@
// Controller state machine: sequences read, evaluate, divide and result.
// Depends on usm_pkg.
module usm_ctrl import usm_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_stall,
  input  logic   out_free,
  output logic   out_load,
  input  stat_t  stat,
  output cmd_t   cmd
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_stall = 1'b1;
    out_load = 1'b0;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.take = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: state_next = S_EXEC;
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (stat.need_div) begin
          cmd.div_go = 1'b1;
          state_next = S_DIV;
        end else state_next = S_OUT;
      end
      S_DIV: if (stat.div_done) state_next = S_OUT;
      S_OUT: if (out_free) begin
        cmd.commit = 1'b1;
        out_load = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

@@ sv/usm_datapath.sv @@
// Datapath: registers, stacks, data memory, ALU and divider.
// Depends on usm_pkg, usm_ram, usm_div.
module usm_datapath import usm_pkg::*; #(
  parameter int OPERAND_STACK_DEPTH = OPERAND_STACK_DEPTH_DEF,
  parameter int DATA_WORDS = DATA_WORDS_DEF,
  parameter int RETURN_STACK_DEPTH = RETURN_STACK_DEPTH_DEF,
  parameter int PROGRAM_WORDS = PROGRAM_WORDS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             cmd,
  output stat_t            stat,
  input  logic [5:0]       op,
  input  logic [WordW-1:0] operand,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_idx,
  input  logic [PcW-1:0]   cfg_val,
  output logic [PcW-1:0]   r_pc,
  output logic [1:0]       r_kind,
  output logic [WordW-1:0] r_value,
  output logic             r_halt,
  output logic [2:0]       r_fault
);
  localparam int SAW = $clog2(OPERAND_STACK_DEPTH);
  localparam int CW = SAW + 1;
  localparam int DAW = $clog2(DATA_WORDS);
  localparam int RAW = $clog2(RETURN_STACK_DEPTH);
  localparam int RCW = RAW + 1;

  logic [PcW-1:0] wsvc, nsvc, rsvc, pc;
  logic stopped;
  logic [CW-1:0] cnt;
  logic [RCW-1:0] rcnt;
  logic [5:0] op_q;
  logic [WordW-1:0] opd_q;
  logic [WordW-1:0] a, b, ta, tb, dm_rd;
  logic [PcW-1:0] rs_rd;

  // Evaluated result, held until commit.
  logic [PcW-1:0] npc_e;
  logic [1:0] kind_e;
  logic [WordW-1:0] val_e, push0_e, push1_e;
  logic halt_e, isdiv_e;
  logic [2:0] flt_e;
  logic [CW-1:0] cnt_e;
  logic [1:0] npush_e;
  logic dm_we_e, rs_push_e, rs_pop_e;
  logic [DAW-1:0] dm_wa_e;
  logic [WordW-1:0] dm_wd_e;
  logic [1:0] phase; // 0 after take, 1 stack read, 2 memory read
  logic [WordW-1:0] mul_q;

  logic [WordW-1:0] quot, rem;
  logic div_done;

  // Stack operands read through two RAMs holding the same contents.
  logic os_we;
  logic [SAW-1:0] os_wa, ra_a, ra_b;
  logic [WordW-1:0] os_wd;
  logic [1:0] wr_step;
  logic commit_ok;

  assign commit_ok = cmd.commit && !stopped && flt_e == F_OK;

  always_ff @(posedge clk) begin
    if (rst) begin
      wsvc <= 12'd4093; nsvc <= 12'd4094; rsvc <= 12'd4095;
      pc <= '0; stopped <= 1'b0; cnt <= '0; rcnt <= '0; wr_step <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_START: begin pc <= cfg_val; stopped <= 1'b0; end
          CFG_WRITE: wsvc <= cfg_val;
          CFG_NEWLINE: nsvc <= cfg_val;
          CFG_READ: rsvc <= cfg_val;
          default: ;
        endcase
      end
      if (cmd.commit && !stopped) begin
        if (flt_e != F_OK) stopped <= 1'b1;
        else begin
          pc <= npc_e;
          cnt <= cnt_e;
          if (halt_e) stopped <= 1'b1;
          if (rs_push_e) rcnt <= rcnt + RCW'(1);
          if (rs_pop_e) rcnt <= rcnt - RCW'(1);
          wr_step <= (npush_e != 2'd0) ? 2'd1 : 2'd0;
        end
      end else if (wr_step != 2'd0) wr_step <= wr_step - 2'd1;
    end
  end

  // A double push writes its lower entry at the commit edge, and the top entry
  // goes in at the next edge, so the next beat always reads settled data.
  assign os_we = (wr_step != 2'd0) || (commit_ok && npush_e == 2'd2);
  assign os_wa = commit_ok ? SAW'(cnt_e - CW'(2)) : SAW'(cnt - CW'(1));
  assign os_wd = commit_ok ? push0_e : ((npush_e == 2'd2) ? push1_e : push0_e);

  assign ra_a = SAW'(cnt - CW'(1));
  assign ra_b = SAW'(cnt - CW'(2));

  usm_ram #(.WIDTH(WordW), .DEPTH(OPERAND_STACK_DEPTH)) u_os_a (
    .clk, .we(os_we), .waddr(os_wa), .wdata(os_wd), .raddr(ra_a), .rdata(ta));
  usm_ram #(.WIDTH(WordW), .DEPTH(OPERAND_STACK_DEPTH)) u_os_b (
    .clk, .we(os_we), .waddr(os_wa), .wdata(os_wd), .raddr(ra_b), .rdata(tb));

  // Data memory read address: direct operand, else the top of stack (ldi).
  logic [DAW-1:0] dm_ra;
  assign dm_ra = (op_q == OP_LDI) ? DAW'(ta) : DAW'(opd_q);
  usm_ram #(.WIDTH(WordW), .DEPTH(DATA_WORDS)) u_dm (
    .clk, .we(cmd.commit && !stopped && flt_e == F_OK && dm_we_e),
    .waddr(dm_wa_e), .wdata(dm_wd_e), .raddr(dm_ra), .rdata(dm_rd));

  logic [PcW-1:0] pc_inc;
  assign pc_inc = (32'(pc) + 32'd1 >= 32'(PROGRAM_WORDS)) ? '0 : pc + 12'd1;

  // The return address is the advanced counter of the calling instruction.
  logic [RAW-1:0] rs_ra;
  assign rs_ra = RAW'(rcnt - RCW'(1));
  usm_ram #(.WIDTH(PcW), .DEPTH(RETURN_STACK_DEPTH)) u_rs (
    .clk, .we(cmd.commit && !stopped && flt_e == F_OK && rs_push_e),
    .waddr(RAW'(rcnt)), .wdata(pc_inc), .raddr(rs_ra), .rdata(rs_rd));

  usm_div u_div (.clk, .rst, .go(cmd.div_go), .dividend(b), .divisor(a),
    .done(div_done), .quot, .rem);

  // Phase counter so that memory data is ready in the cycle after stack data.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_q <= op; opd_q <= operand; phase <= 2'd0;
    end else if (phase != 2'd3) phase <= phase + 2'd1;
    mul_q <= ta * tb;
  end

  always_comb begin
    a = (pops_of(op_q) >= 2'd1) ? ta : '0;
    b = (pops_of(op_q) == 2'd2) ? tb : '0;
  end

  logic sgt, slt;
  assign sgt = $signed(b) > $signed(a);
  assign slt = $signed(b) < $signed(a);

  // Evaluate at exec; memory-read and divide results patched in later.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      logic [CW:0] after;
      logic [1:0] np;
      logic [WordW-1:0] r;
      np = pushes_of(op_q);
      after = (CW+1)'(cnt) - (CW+1)'(pops_of(op_q)) + (CW+1)'(np);
      npc_e <= pc_inc; kind_e <= K_NONE; val_e <= '0; halt_e <= 1'b0;
      flt_e <= F_OK; npush_e <= np; dm_we_e <= 1'b0; rs_push_e <= 1'b0;
      rs_pop_e <= 1'b0; isdiv_e <= 1'b0;
      cnt_e <= CW'(after);
      dm_wa_e <= DAW'(opd_q); dm_wd_e <= a;
      r = '0;
      case (op_q)
        OP_NOT: r = {31'd0, a == 0};
        OP_NEG: r = 32'd0 - a;
        OP_INC: r = a + 1;
        OP_DEC: r = a - 1;
        OP_ADD: r = b + a;
        OP_SUB: r = b - a;
        OP_GT: r = {31'd0, sgt};
        OP_LT: r = {31'd0, slt};
        OP_GE: r = {31'd0, !slt};
        OP_LE: r = {31'd0, !sgt};
        OP_EQ: r = {31'd0, b == a};
        OP_NE: r = {31'd0, b != a};
        OP_AND: r = {31'd0, b != 0 && a != 0};
        OP_OR: r = {31'd0, b != 0 || a != 0};
        OP_LDA, OP_LDC: r = opd_q;
        default: r = a;
      endcase
      push0_e <= r;
      push1_e <= (op_q == OP_SWP) ? b : a;
      if (op_q > OP_LAST) flt_e <= F_ILLEGAL;
      else if (cnt < CW'(pops_of(op_q))) flt_e <= F_UNDERFLOW;
      else if (after > (CW+1)'(OPERAND_STACK_DEPTH)) flt_e <= F_OVERFLOW;
      else begin
        case (op_q)
          OP_LOD, OP_STR: if (opd_q >= 32'(DATA_WORDS)) flt_e <= F_BADADDR;
          OP_LDI: if (a >= 32'(DATA_WORDS)) flt_e <= F_BADADDR;
          OP_STI: begin
            if (b >= 32'(DATA_WORDS)) flt_e <= F_BADADDR;
            dm_wa_e <= DAW'(b);
          end
          OP_DIV, OP_MOD: begin
            if (a == 0) flt_e <= F_DIVZERO;
            isdiv_e <= 1'b1;
          end
          OP_UJP: if (opd_q >= 32'(PROGRAM_WORDS)) flt_e <= F_BADADDR;
                  else npc_e <= PcW'(opd_q);
          OP_TJP, OP_FJP: if ((a != 0) == (op_q == OP_TJP)) begin
            if (opd_q >= 32'(PROGRAM_WORDS)) flt_e <= F_BADADDR;
            else npc_e <= PcW'(opd_q);
          end
          OP_CALL: begin
            if (opd_q == 32'(wsvc)) begin
              if (cnt == '0) flt_e <= F_UNDERFLOW;
              else begin
                kind_e <= K_NUMBER; val_e <= ta; cnt_e <= cnt - CW'(1);
              end
            end else if (opd_q == 32'(nsvc)) kind_e <= K_NEWLINE;
            else if (opd_q == 32'(rsvc)) ;
            else if (opd_q >= 32'(PROGRAM_WORDS)) flt_e <= F_BADADDR;
            else if (rcnt >= RCW'(RETURN_STACK_DEPTH)) flt_e <= F_OVERFLOW;
            else begin
              rs_push_e <= 1'b1; npc_e <= PcW'(opd_q);
            end
          end
          OP_END: if (rcnt == '0) halt_e <= 1'b1;
                  else begin rs_pop_e <= 1'b1; npc_e <= rs_rd; end
          default: ;
        endcase
        dm_we_e <= (op_q == OP_STR || op_q == OP_STI);
      end
    end else begin
      // Data memory and product arrive in the cycle after exec.
      if (phase == 2'd2) begin
        if (op_q == OP_LOD || op_q == OP_LDI) push0_e <= dm_rd;
        if (op_q == OP_MULT) push0_e <= mul_q;
      end
      if (div_done) begin
        if ($signed(b) == -32'sd2147483648 && a == '1)
          push0_e <= (op_q == OP_DIV) ? 32'h8000_0000 : '0;
        else push0_e <= (op_q == OP_DIV) ? quot : rem;
      end
    end
  end

  assign stat.need_div = (op_q == OP_DIV || op_q == OP_MOD) && ta != 0 &&
                         (cnt >= CW'(2));
  assign stat.div_done = div_done;

  // Result beat.
  always_comb begin
    if (stopped) begin
      r_pc = pc; r_kind = K_NONE; r_value = '0; r_halt = 1'b1; r_fault = F_OK;
    end else if (flt_e != F_OK) begin
      r_pc = pc; r_kind = K_NONE; r_value = '0; r_halt = 1'b1; r_fault = flt_e;
    end else begin
      r_pc = npc_e; r_kind = kind_e; r_value = val_e; r_halt = halt_e; r_fault = F_OK;
    end
  end

  logic unused;
  assign unused = isdiv_e;
endmodule

@@ sv/ucode_stack_machine_execute.sv @@
// Top level of the stack machine instruction executor.
// Depends on usm_pkg, usm_ctrl, usm_datapath and the defines header.
//
//  channel | direction | handshake           | payload
//  in      | input     | in_valid/in_stall   | op, operand
//  out     | output    | out_valid/out_stall | next_pc, out_kind, out_value, halted, fault
//  cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// An instruction passes through take, stack read, evaluate and result;
// DIV and MOD also wait for the radix-2 divider. The output register
// holds a result while the next instruction is read. Reset is synchronous and
// clears control state; the stacks and data memory are not cleared. Out stall
// only delays the commit of the held instruction.
`include "ucode_stack_machine_execute_defines.svh"
module ucode_stack_machine_execute import usm_pkg::*; #(
  parameter int OPERAND_STACK_DEPTH = OPERAND_STACK_DEPTH_DEF,
  parameter int DATA_WORDS = DATA_WORDS_DEF,
  parameter int RETURN_STACK_DEPTH = RETURN_STACK_DEPTH_DEF,
  parameter int PROGRAM_WORDS = PROGRAM_WORDS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [5:0]       op,
  input  logic signed [31:0] operand,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [11:0]      next_pc,
  output logic [1:0]       out_kind,
  output logic signed [31:0] out_value,
  output logic             halted,
  output logic [2:0]       fault,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [11:0]      cfg_data
);
  cmd_t cmd;
  stat_t stat;
  logic out_load, out_free;
  logic [PcW-1:0] r_pc;
  logic [1:0] r_kind;
  logic [WordW-1:0] r_value;
  logic r_halt;
  logic [2:0] r_fault;

  assign cfg_ready = 1'b1;
  assign out_free = !out_valid || !out_stall;

  usm_ctrl u_ctrl (.clk, .rst, .in_valid, .in_stall, .out_free, .out_load, .stat, .cmd);

  usm_datapath #(.OPERAND_STACK_DEPTH(OPERAND_STACK_DEPTH), .DATA_WORDS(DATA_WORDS),
    .RETURN_STACK_DEPTH(RETURN_STACK_DEPTH), .PROGRAM_WORDS(PROGRAM_WORDS)) u_dp (
    .clk, .rst, .cmd, .stat, .op, .operand,
    .cfg_we(cfg_valid && cfg_ready), .cfg_idx(cfg_index), .cfg_val(cfg_data),
    .r_pc, .r_kind, .r_value, .r_halt, .r_fault);

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (out_load) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
    if (out_load) begin
      next_pc <= r_pc; out_kind <= r_kind; out_value <= r_value;
      halted <= r_halt; fault <= r_fault;
    end
  end

  `USM_ASSERT(a_fault_halts, clk, rst, out_valid && fault != F_OK |-> halted, "fault without halt")
  `USM_ASSERT(a_kind_ok, clk, rst, out_valid |-> out_kind != 2'd3, "bad output kind")
  `USM_ASSERT_HOLD(a_out_hold, clk, rst, out_valid && out_stall, next_pc, "result moved in stall")
endmodule
